[src/key_matrix_scanner_defines.svh]
// Assertion helpers shared by the scanner RTL.
`ifndef KEY_MATRIX_SCANNER_DEFINES_SVH
`define KEY_MATRIX_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KMS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KMS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/kms_pkg.sv]
package kms_pkg;

  localparam int TBL_ROWS = 8;
  localparam int TBL_COLS = 10;
  localparam int ROWS_DEF = 8;
  localparam int COLS_DEF = 10;
  localparam int ROW_W    = $clog2(TBL_ROWS);
  localparam int COL_W    = $clog2(TBL_COLS);
  localparam int CODE_W   = 8;
  localparam int CODES    = 1 << CODE_W;
  localparam int RET_W    = 10;
  localparam int DIP_W    = 4;
  localparam int DIP_BIT  = 9;

  localparam logic [RET_W-1:0]  RETURN_IDLE = 10'h3ff;
  localparam logic [7:0]        STROBE_IDLE = 8'hff;
  localparam logic [CODE_W-1:0] NO_KEY      = 8'h00;
  localparam logic [CODE_W-1:0] KEEP_FIRST  = 8'h10;
  localparam logic [CODE_W-1:0] KEEP_LAST   = 8'h12;

  // Codes 0x10 to 0x12 survive a strobe of zero.
  localparam logic [CODES-1:0] KEEP_MASK = {{(CODES-3){1'b0}}, 3'b111} << KEEP_FIRST;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_STROBE  = 2'd2
  } kms_cmd_t;

  typedef struct packed {
    logic              wr_en;
    logic              wr_data;
    logic              rd_en;
    logic              clear;
    logic [CODE_W-1:0] addr;
  } kms_store_req_t;

  localparam logic [CODE_W-1:0] CELL_CODE [TBL_ROWS][TBL_COLS] = '{
    '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h70, 8'h00},
    '{8'h38, 8'h39, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'h71, 8'h00},
    '{8'hc0, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h72, 8'h00},
    '{8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h73, 8'h00},
    '{8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h74, 8'h00},
    '{8'h58, 8'h59, 8'h5a, 8'hdb, 8'hdd, 8'hdc, 8'h27, 8'h25, 8'h22, 8'h10},
    '{8'h0d, 8'h20, 8'h09, 8'h00, 8'h00, 8'h78, 8'h00, 8'h34, 8'h00, 8'h11},
    '{8'h79, 8'h7a, 8'h77, 8'h75, 8'h2e, 8'h76, 8'h00, 8'h00, 8'h00, 8'h21}
  };

  // A code interrupts when it sits in the matrix, the shift-style keys excepted.
  function automatic logic irq_capable(input logic [CODE_W-1:0] code);
    logic hit;
    hit = 1'b0;
    for (int r = 0; r < TBL_ROWS; r++) begin
      for (int c = 0; c < TBL_COLS; c++) begin
        if (CELL_CODE[r][c] != NO_KEY && CELL_CODE[r][c] == code) begin
          hit = 1'b1;
        end
      end
    end
    if (code >= KEEP_FIRST && code <= KEEP_LAST) begin
      hit = 1'b0;
    end
    return hit;
  endfunction

endpackage

[src/key_matrix_scanner.sv]
// Channel  Handshake                 Payload
// in       start / busy              in_command, in_key_code, in_strobe_req
// out      out_valid (one cycle)     out_return_word, out_key_irq, out_key_line
// cfg      cfg_valid / cfg_ready     cfg_dip_switches
//
// A key press, key release, unknown command or unchanged strobe is handled in the idle state;
// its result beat appears in the next cycle and busy stays low.
// A strobe write that changes the strobe keeps busy high after the accept through
// the scan: one read of the key store port per matrix cell, then a drain state
// for the last compare. The result beat follows in the next cycle.
// Reset is synchronous and active low; the key store valid bits clear at once.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`include "key_matrix_scanner_defines.svh"

module key_matrix_scanner #(
  parameter int ROWS = kms_pkg::ROWS_DEF,
  parameter int COLS = kms_pkg::COLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic [kms_pkg::CODE_W-1:0] in_key_code,
  input  logic [7:0]                 in_strobe_req,
  output logic                       out_valid,
  output logic [kms_pkg::RET_W-1:0]  out_return_word,
  output logic                       out_key_irq,
  output logic                       out_key_line,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kms_pkg::DIP_W-1:0]  cfg_dip_switches
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  localparam logic [kms_pkg::ROW_W-1:0] ROW_LAST = kms_pkg::ROW_W'(ROWS - 1);
  localparam logic [kms_pkg::COL_W-1:0] COL_LAST = kms_pkg::COL_W'(COLS - 1);
  localparam logic [kms_pkg::ROW_W-1:0] DIP_ROWS = kms_pkg::ROW_W'(kms_pkg::DIP_W);

  state_t                          state_r;
  logic [7:0]                      strobe_r;
  logic [kms_pkg::RET_W-1:0]       return_r;
  logic                            irq_r;
  logic                            line_r;
  logic [kms_pkg::DIP_W-1:0]       dip_r;
  logic                            out_valid_r;
  logic [kms_pkg::ROW_W-1:0]       row_r;
  logic [kms_pkg::COL_W-1:0]       col_r;
  logic                            chk_en_r;
  logic [kms_pkg::COL_W-1:0]       chk_col_r;
  logic                            accept;
  logic                            pressed_q;
  logic [kms_pkg::CODE_W-1:0]      cell_code;
  logic [kms_pkg::RET_W-1:0]       ret_clr;
  kms_pkg::kms_cmd_t               cmd;
  kms_pkg::kms_store_req_t         store_req;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cmd       = kms_pkg::kms_cmd_t'(in_command);
  assign cell_code = kms_pkg::CELL_CODE[row_r][col_r];
  assign cfg_ready = 1'b1;

  always_comb begin
    store_req         = '0;
    store_req.addr    = in_key_code;
    store_req.wr_data = (cmd == kms_pkg::CMD_PRESS);
    if (state_r == ST_SCAN) begin
      store_req.rd_en = 1'b1;
      store_req.addr  = cell_code;
    end else if (accept) begin
      store_req.wr_en = (cmd == kms_pkg::CMD_PRESS) || (cmd == kms_pkg::CMD_RELEASE);
      store_req.clear = (cmd == kms_pkg::CMD_STROBE) && (in_strobe_req != strobe_r) &&
                        (in_strobe_req == 8'h00);
    end
  end

  // Return bits pulled low this cycle: the column whose store read is back,
  // and the DIP line at the end of a strobed row whose DIP switch is on.
  always_comb begin
    ret_clr = '0;
    if (chk_en_r && pressed_q) begin
      ret_clr[chk_col_r] = 1'b1;
    end
    if (state_r == ST_SCAN && col_r == COL_LAST && row_r < DIP_ROWS && !strobe_r[row_r] &&
        dip_r[row_r[$clog2(kms_pkg::DIP_W)-1:0]]) begin
      ret_clr[kms_pkg::DIP_BIT] = 1'b1;
    end
  end

  kms_key_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (store_req),
    .pressed_q (pressed_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      strobe_r    <= kms_pkg::STROBE_IDLE;
      return_r    <= kms_pkg::RETURN_IDLE;
      irq_r       <= 1'b0;
      line_r      <= 1'b1;
      dip_r       <= '0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      chk_en_r    <= 1'b0;
      chk_col_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      chk_en_r    <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        dip_r <= cfg_dip_switches;
      end
      // Compare stage: the store read issued last cycle is back.
      if (ret_clr != '0) begin
        return_r <= return_r & ~ret_clr;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd)
              kms_pkg::CMD_PRESS: begin
                out_valid_r <= 1'b1;
                if (kms_pkg::irq_capable(in_key_code)) begin
                  irq_r  <= 1'b1;
                  line_r <= 1'b0;
                end
              end
              kms_pkg::CMD_RELEASE: begin
                out_valid_r <= 1'b1;
              end
              kms_pkg::CMD_STROBE: begin
                if (in_strobe_req == strobe_r) begin
                  out_valid_r <= 1'b1;
                end else begin
                  strobe_r <= in_strobe_req;
                  return_r <= kms_pkg::RETURN_IDLE;
                  row_r    <= '0;
                  col_r    <= '0;
                  state_r  <= ST_SCAN;
                  if (in_strobe_req == 8'h00) begin
                    irq_r  <= 1'b0;
                    line_r <= 1'b1;
                  end
                end
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          chk_en_r  <= !strobe_r[row_r] && (cell_code != kms_pkg::NO_KEY);
          chk_col_r <= col_r;
          if (col_r == COL_LAST) begin
            col_r <= '0;
            if (row_r == ROW_LAST) begin
              state_r <= ST_DRAIN;
            end else begin
              row_r <= row_r + 1'b1;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_return_word = return_r;
  assign out_key_irq     = irq_r;
  assign out_key_line    = line_r;

  `KMS_ASSERT_NXT(a_quick_result, clk, rst_n, accept && cmd != kms_pkg::CMD_STROBE, out_valid, "key event gave no result beat")
  `KMS_ASSERT_IMP(a_no_beat_busy, clk, rst_n, state_r != ST_IDLE, !out_valid_r, "result beat during scan")
  `KMS_ASSERT_NXT(a_scan_stable, clk, rst_n, state_r == ST_SCAN, $stable(irq_r) && $stable(strobe_r), "irq or strobe moved during scan")
  `KMS_ASSERT_IMP(a_line_irq, clk, rst_n, 1'b1, out_key_line != out_key_irq, "key line and irq disagree")

endmodule

[src/kms_key_store.sv]
module kms_key_store (
  input  logic                   clk,
  input  logic                   rst_n,
  input  kms_pkg::kms_store_req_t req,
  output logic                   pressed_q
);

  logic                      mem [kms_pkg::CODES];
  logic [kms_pkg::CODES-1:0] vld_r;
  logic                      mem_q_r;
  logic                      vld_q_r;

  // An entry whose valid bit is clear reads as released.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.clear) begin
        vld_r <= vld_r & kms_pkg::KEEP_MASK;
      end else if (req.wr_en) begin
        vld_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        vld_q_r <= vld_r[req.addr];
      end
    end
  end

  assign pressed_q = mem_q_r & vld_q_r;

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RET_W   = kms_pkg::RET_W;
  localparam int CODE_W  = kms_pkg::CODE_W;
  localparam int DIP_W   = kms_pkg::DIP_W;
  localparam int CODES   = kms_pkg::CODES;
  localparam int DIP_BIT = kms_pkg::DIP_BIT;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int IDLE_PCT    = 22;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_ITEMS = 306;
  localparam int MAT_ROWS    = 8;
  localparam int MAT_COLS    = 10;

  // Key code of each matrix cell, row by row; zero marks an empty cell.
  localparam logic [0:79][7:0] MATRIX_CODE = {
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h70, 8'h00,
    8'h38, 8'h39, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hbf, 8'h71, 8'h00,
    8'hc0, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h72, 8'h00,
    8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f, 8'h73, 8'h00,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h74, 8'h00,
    8'h58, 8'h59, 8'h5a, 8'hdb, 8'hdd, 8'hdc, 8'h27, 8'h25, 8'h22, 8'h10,
    8'h0d, 8'h20, 8'h09, 8'h00, 8'h00, 8'h78, 8'h00, 8'h34, 8'h00, 8'h11,
    8'h79, 8'h7a, 8'h77, 8'h75, 8'h2e, 8'h76, 8'h00, 8'h00, 8'h00, 8'h21
  };

  typedef struct packed {
    logic [RET_W-1:0] return_word;
    logic             key_irq;
    logic             key_line;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = 2'd0;
  logic [CODE_W-1:0] in_key_code = '0;
  logic [7:0] in_strobe_req = 8'hff;
  logic out_valid;
  logic [RET_W-1:0] out_return_word;
  logic out_key_irq;
  logic out_key_line;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DIP_W-1:0] cfg_dip_switches = '0;

  // Scanner state as the block should hold it.
  logic [CODES-1:0] held_model;
  logic [CODES-1:0] irq_wake;
  logic [7:0]       strobe_held;
  logic [RET_W-1:0] return_held;
  logic             irq_pending;
  logic             line_high;
  logic [DIP_W-1:0] dip_model;

  scan_result_t scan_results_due[$];
  bit gaps_on = 1'b1;
  int errors = 0;
  int items_sent = 0;
  int presses = 0;
  int releases = 0;
  int rescans = 0;
  int beats_checked = 0;
  int dip_writes = 0;
  int stall_cycles = 0;

  key_matrix_scanner u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_key_code      (in_key_code),
    .in_strobe_req    (in_strobe_req),
    .out_valid        (out_valid),
    .out_return_word  (out_return_word),
    .out_key_irq      (out_key_irq),
    .out_key_line     (out_key_line),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_dip_switches (cfg_dip_switches)
  );

  always #5 clk = ~clk;

  task automatic reset_matrix_state();
    logic [7:0] code;
    held_model = '0;
    irq_wake = '0;
    for (int i = 0; i < MAT_ROWS * MAT_COLS; i++) begin
      code = MATRIX_CODE[i];
      if (code != 8'h00) begin
        irq_wake[code] = 1'b1;
      end
    end
    irq_wake[8'h10] = 1'b0;
    irq_wake[8'h11] = 1'b0;
    irq_wake[8'h12] = 1'b0;
    strobe_held = 8'hff;
    return_held = 10'h3ff;
    irq_pending = 1'b0;
    line_high = 1'b1;
    dip_model = '0;
  endtask

  task automatic rescan_matrix();
    logic [CODES-1:0] held_keys;
    logic [7:0] code;
    return_held = 10'h3ff;
    if (strobe_held == 8'h00) begin
      // The modifier keys 0x10 to 0x12 survive a full strobe.
      held_keys = '0;
      held_keys[8'h10] = held_model[8'h10];
      held_keys[8'h11] = held_model[8'h11];
      held_keys[8'h12] = held_model[8'h12];
      held_model = held_keys;
      irq_pending = 1'b0;
      line_high = 1'b1;
    end
    for (int r = 0; r < MAT_ROWS; r++) begin
      if (!strobe_held[r]) begin
        for (int c = 0; c < MAT_COLS; c++) begin
          code = MATRIX_CODE[r * MAT_COLS + c];
          if (code != 8'h00 && held_model[code]) begin
            return_held[c] = 1'b0;
          end
        end
        if (r < DIP_W && dip_model[r]) begin
          return_held[DIP_BIT] = 1'b0;
        end
      end
    end
    rescans++;
  endtask

  task automatic apply_matrix_item(input logic [1:0] cmd, input logic [7:0] code,
                                   input logic [7:0] strobe, output scan_result_t res);
    unique case (cmd)
      kms_pkg::CMD_PRESS: begin
        held_model[code] = 1'b1;
        if (irq_wake[code]) begin
          irq_pending = 1'b1;
          line_high = 1'b0;
        end
        presses++;
      end
      kms_pkg::CMD_RELEASE: begin
        held_model[code] = 1'b0;
        releases++;
      end
      kms_pkg::CMD_STROBE: begin
        if (strobe != strobe_held) begin
          strobe_held = strobe;
          rescan_matrix();
        end
      end
      default: begin
      end
    endcase
    res.return_word = return_held;
    res.key_irq = irq_pending;
    res.key_line = line_high;
  endtask

  task automatic report_mismatch(input string what, input logic [RET_W-1:0] got,
                                 input logic [RET_W-1:0] want);
    $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // The previous beat leaves start high; start is driven low only for the random idle gaps.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] code,
                           input logic [7:0] strobe);
    scan_result_t res;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_key_code <= code;
    in_strobe_req <= strobe;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_matrix_item(cmd, code, strobe, res);
    scan_results_due.push_back(res);
    items_sent++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (scan_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_dip(input logic [DIP_W-1:0] value);
    cfg_dip_switches <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    dip_model = value;
    dip_writes++;
    @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [1:0] cmd;
    logic [7:0] code;
    logic [7:0] strobe;
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) begin
      cmd = kms_pkg::CMD_PRESS;
    end else if (roll < 65) begin
      cmd = kms_pkg::CMD_RELEASE;
    end else if (roll < 94) begin
      cmd = kms_pkg::CMD_STROBE;
    end else begin
      cmd = CMD_UNKNOWN;
    end
    code = ($urandom_range(3) == 0) ? 8'($urandom) : MATRIX_CODE[$urandom_range(79)];
    roll = $urandom_range(99);
    if (roll < 45) begin
      strobe = 8'($urandom);
    end else if (roll < 75) begin
      strobe = ~(8'h01 << $urandom_range(7));
    end else if (roll < 85) begin
      strobe = strobe_held;
    end else if (roll < 93) begin
      strobe = 8'hff;
    end else begin
      strobe = 8'h00;
    end
    send_item(cmd, code, strobe);
  endtask

  task automatic test_reset_outputs();
    send_item(CMD_UNKNOWN, 8'hff, 8'hff);
    wait_all_results();
  endtask

  task automatic test_key_events();
    send_item(kms_pkg::CMD_PRESS, 8'h00, 8'h00);
    send_item(kms_pkg::CMD_PRESS, 8'h10, 8'hff);
    send_item(kms_pkg::CMD_PRESS, 8'hff, 8'h00);
    send_item(kms_pkg::CMD_RELEASE, 8'hff, 8'hff);
    send_item(kms_pkg::CMD_PRESS, 8'h30, 8'h55);
    send_item(kms_pkg::CMD_RELEASE, 8'h30, 8'haa);
    send_item(kms_pkg::CMD_PRESS, 8'h30, 8'h00);
    send_item(CMD_UNKNOWN, 8'h00, 8'h00);
    wait_all_results();
  endtask

  task automatic test_strobe_scan();
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'hfe);
    send_item(kms_pkg::CMD_STROBE, 8'hff, 8'hfe);
    send_item(kms_pkg::CMD_PRESS, 8'h11, 8'hfe);
    send_item(kms_pkg::CMD_PRESS, 8'h34, 8'hfe);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'hbe);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'h00);
    send_item(kms_pkg::CMD_RELEASE, 8'h11, 8'h00);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'hff);
    wait_all_results();
  endtask

  task automatic test_dip_rows();
    write_dip(4'hf);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'hf0);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'h0f);
    wait_all_results();
    write_dip(4'h5);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'hfd);
    send_item(kms_pkg::CMD_STROBE, 8'h00, 8'hfb);
    wait_all_results();
  endtask

  task automatic test_random_traffic();
    logic [DIP_W-1:0] dip_plan [5];
    dip_plan[0] = 4'h0;
    dip_plan[1] = 4'hf;
    dip_plan[2] = 4'($urandom);
    dip_plan[3] = 4'ha;
    dip_plan[4] = 4'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_dip(dip_plan[p]);
      // One whole phase runs with the sender never pausing.
      gaps_on = (p != 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) begin
          wait_all_results();
        end
        send_random_item();
      end
      wait_all_results();
    end
    gaps_on = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    scan_result_t want;
    if (rst_n && out_valid) begin
      if (scan_results_due.size() == 0) begin
        report_mismatch("unexpected beat, return_word", out_return_word, '0);
      end else begin
        want = scan_results_due.pop_front();
        beats_checked++;
        if (out_return_word !== want.return_word) begin
          report_mismatch("return_word", out_return_word, want.return_word);
        end
        if (out_key_irq !== want.key_irq) begin
          report_mismatch("key_irq", RET_W'(out_key_irq), RET_W'(want.key_irq));
        end
        if (out_key_line !== want.key_line) begin
          report_mismatch("key_line", RET_W'(out_key_line), RET_W'(want.key_line));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    reset_matrix_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_outputs();
    test_key_events();
    test_strobe_scan();
    test_dip_rows();
    test_random_traffic();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d presses, %0d releases, %0d strobe rescans",
             items_sent, presses, releases, rescans);
    $display("Checked %0d result beats across %0d DIP switch settings",
             beats_checked, dip_writes);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
